@@ design/fekvc_pkg.sv @@
// shared types and constants for the fifo evicting key value cache
package fekvc_pkg;

  // field widths of the stream words
  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned LimitW  = 7;
  localparam int unsigned TotalW  = 8;
  localparam int unsigned InDataW = 64;
  localparam int unsigned OutDataW = 104;

  // reset value of the capacity limit register
  localparam logic [LimitW-1:0] LimitReset = 7'd65;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EV_RD,
    ST_EV_CAP,
    ST_APPEND,
    ST_SHIFT,
    ST_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic search_step;
    logic shift_start;
    logic shift_step;
    logic ev_read;
    logic ev_take;
    logic append;
    logic drop;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic val_zero;
    logic search_done;
    logic hit;
    logic evict_need;
    logic shift_done;
    logic out_busy;
  } stat_t;

endpackage

@@ design/fekvc_ctrl.sv @@
// controller state machine sequencing search, eviction, append and shift
module fekvc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  fekvc_pkg::stat_t  stat_i,
  output fekvc_pkg::cmd_t   cmd_o
);

  fekvc_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fekvc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      fekvc_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fekvc_pkg::ST_SEARCH;
        end
      end
      fekvc_pkg::ST_SEARCH: begin
        if (!stat_i.search_done) begin
          cmd_o.search_step = 1'b1;
        end else begin
          case (stat_i.op)
            fekvc_pkg::OP_INSERT: begin
              if (stat_i.hit || stat_i.val_zero) begin
                state_d = fekvc_pkg::ST_DONE;
              end else if (stat_i.evict_need) begin
                state_d = fekvc_pkg::ST_EV_RD;
              end else begin
                state_d = fekvc_pkg::ST_APPEND;
              end
            end
            fekvc_pkg::OP_REMOVE: begin
              if (stat_i.hit) begin
                cmd_o.shift_start = 1'b1;
                state_d           = fekvc_pkg::ST_SHIFT;
              end else begin
                state_d = fekvc_pkg::ST_DONE;
              end
            end
            default: state_d = fekvc_pkg::ST_DONE;
          endcase
        end
      end
      fekvc_pkg::ST_EV_RD: begin
        cmd_o.ev_read = 1'b1;
        state_d       = fekvc_pkg::ST_EV_CAP;
      end
      fekvc_pkg::ST_EV_CAP: begin
        cmd_o.ev_take = 1'b1;
        state_d       = fekvc_pkg::ST_APPEND;
      end
      fekvc_pkg::ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = fekvc_pkg::ST_DONE;
      end
      fekvc_pkg::ST_SHIFT: begin
        if (stat_i.shift_done) begin
          cmd_o.drop = 1'b1;
          state_d    = fekvc_pkg::ST_DONE;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      fekvc_pkg::ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = fekvc_pkg::ST_IDLE;
        end
      end
      default: state_d = fekvc_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ design/fekvc_dp.sv @@
// datapath: entry memory in insertion order, walk pointers and result register
module fekvc_dp #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fekvc_pkg::LimitW-1:0]        cfg_wdata_i,
  input  logic [fekvc_pkg::InDataW-1:0]       s_tdata_i,
  input  logic [1:0]                          s_tuser_i,
  input  fekvc_pkg::cmd_t                     cmd_i,
  output fekvc_pkg::stat_t                    stat_o,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [fekvc_pkg::OutDataW-1:0]      m_tdata_o,
  output logic [1:0]                          m_tuser_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > fekvc_pkg::LimitW) ? CW : fekvc_pkg::LimitW;
  localparam int unsigned SW   = AW + 2;
  localparam int unsigned EW   = fekvc_pkg::KeyW + fekvc_pkg::ValW;

  // wrap a physical pointer at the top of the memory
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // entry memory: key in low half, value in high half
  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rdata_q;

  fekvc_pkg::op_e               op_q;
  logic [fekvc_pkg::KeyW-1:0]   key_q;
  logic [fekvc_pkg::ValW-1:0]   val_q;
  logic [fekvc_pkg::LimitW-1:0] limit_q;
  logic [AW-1:0]                head_q;
  logic [CW-1:0]                count_q;
  logic [CW-1:0]                idx_q;
  logic [AW-1:0]                ptr_q;
  logic                         rvld_q;
  logic [CW-1:0]                ridx_q;
  logic [AW-1:0]                rphys_q;
  logic                         hit_q;
  logic [CW-1:0]                hit_idx_q;
  logic [AW-1:0]                hit_phys_q;
  logic [fekvc_pkg::ValW-1:0]   hit_val_q;
  logic [AW-1:0]                dst_q;
  logic                         ev_q;
  logic [fekvc_pkg::KeyW-1:0]   ev_key_q;
  logic [fekvc_pkg::ValW-1:0]   ev_val_q;
  logic                         ins_ok_q;
  logic                         m_valid_q;
  logic                         found_q;
  logic                         evicted_q;
  logic [fekvc_pkg::ValW-1:0]   rd_out_q;
  logic [fekvc_pkg::KeyW-1:0]   ev_key_out_q;
  logic [fekvc_pkg::ValW-1:0]   ev_val_out_q;
  logic [fekvc_pkg::TotalW-1:0] total_q;

  logic          key_match;
  logic          issue_srch;
  logic          issue_shift;
  logic          issue;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic          found_d;
  logic [fekvc_pkg::ValW-1:0] rd_d;

  // walk control
  assign key_match   = rvld_q && (rdata_q[fekvc_pkg::KeyW-1:0] == key_q);
  assign issue_srch  = cmd_i.search_step && !hit_q && (idx_q < count_q);
  assign issue_shift = cmd_i.shift_step && (idx_q < count_q);
  assign issue       = issue_srch || issue_shift;
  assign raddr       = cmd_i.ev_read ? head_q : ptr_q;

  // append position after the youngest entry
  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  // memory write: append or move down one place
  assign we    = cmd_i.append || (cmd_i.shift_step && rvld_q);
  assign waddr = cmd_i.append ? tail : dst_q;
  assign wdata = cmd_i.append ? {val_q, key_q} : rdata_q;

  // entry memory with registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // status to controller
  assign stat_o.op          = op_q;
  assign stat_o.val_zero    = (val_q == '0);
  assign stat_o.search_done = hit_q || ((idx_q >= count_q) && !rvld_q);
  assign stat_o.hit         = hit_q;
  assign stat_o.evict_need  = (CMPW'(count_q) > CMPW'(limit_q)) || (count_q >= CW'(DEPTH));
  assign stat_o.shift_done  = (idx_q >= count_q) && !rvld_q;
  assign stat_o.out_busy    = m_valid_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= fekvc_pkg::LimitReset;
      head_q    <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      ptr_q     <= '0;
      rvld_q    <= 1'b0;
      hit_q     <= 1'b0;
      dst_q     <= '0;
      ev_q      <= 1'b0;
      ins_ok_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      // walk pointers
      if (cmd_i.load) begin
        idx_q <= '0;
        ptr_q <= head_q;
      end else if (cmd_i.shift_start) begin
        idx_q <= hit_idx_q + 1'b1;
        ptr_q <= wrap_inc(hit_phys_q);
      end else if (issue) begin
        idx_q <= idx_q + 1'b1;
        ptr_q <= wrap_inc(ptr_q);
      end
      rvld_q <= issue;
      // hit flag
      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end else if (cmd_i.search_step && key_match && !hit_q) begin
        hit_q <= 1'b1;
      end
      // destination of the moving entries
      if (cmd_i.shift_start) begin
        dst_q <= hit_phys_q;
      end else if (cmd_i.shift_step && rvld_q) begin
        dst_q <= wrap_inc(dst_q);
      end
      // head and count
      if (cmd_i.ev_take) begin
        head_q  <= wrap_inc(head_q);
        count_q <= count_q - 1'b1;
      end else if (cmd_i.append) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.drop) begin
        count_q <= count_q - 1'b1;
      end
      // per item flags
      if (cmd_i.load) begin
        ev_q     <= 1'b0;
        ins_ok_q <= 1'b0;
      end else begin
        if (cmd_i.ev_take) begin
          ev_q <= 1'b1;
        end
        if (cmd_i.append) begin
          ins_ok_q <= 1'b1;
        end
      end
      // output word valid
      if (cmd_i.finish) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // result fields for the finished item
  always_comb begin
    found_d = 1'b0;
    rd_d    = '0;
    case (op_q) inside
      fekvc_pkg::OP_INSERT: found_d = ins_ok_q;
      fekvc_pkg::OP_LOOKUP, fekvc_pkg::OP_REMOVE: begin
        found_d = hit_q;
        rd_d    = hit_q ? hit_val_q : '0;
      end
      default: found_d = 1'b0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= s_tdata_i[fekvc_pkg::KeyW-1:0];
      val_q <= s_tdata_i[fekvc_pkg::InDataW-1:fekvc_pkg::KeyW];
      op_q  <= fekvc_pkg::op_e'(s_tuser_i);
    end
    if (issue) begin
      ridx_q  <= idx_q;
      rphys_q <= ptr_q;
    end
    if (cmd_i.search_step && key_match && !hit_q) begin
      hit_idx_q  <= ridx_q;
      hit_phys_q <= rphys_q;
      hit_val_q  <= rdata_q[EW-1:fekvc_pkg::KeyW];
    end
    if (cmd_i.ev_take) begin
      ev_key_q <= rdata_q[fekvc_pkg::KeyW-1:0];
      ev_val_q <= rdata_q[EW-1:fekvc_pkg::KeyW];
    end
    if (cmd_i.finish) begin
      found_q      <= found_d;
      evicted_q    <= ev_q;
      rd_out_q     <= rd_d;
      ev_key_out_q <= ev_q ? ev_key_q : '0;
      ev_val_out_q <= ev_q ? ev_val_q : '0;
      total_q      <= fekvc_pkg::TotalW'(count_q);
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {total_q, ev_val_out_q, ev_key_out_q, rd_out_q};
  assign m_tuser_o  = {evicted_q, found_q};

  // the count never runs past the memory
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // an append always finds a free place
  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> (count_q < CW'(DEPTH)))
    else $error("append into a full store");

  // a result never overwrites one still waiting
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !m_valid_q)
    else $error("result register overwritten");

  // a remove that hit lowers the count by exactly one
  a_drop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drop |=> (count_q == $past(count_q) - 1'b1))
    else $error("remove did not lower the count");

  // eviction only takes place from a non-empty store
  a_evict_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ev_take |-> (count_q != '0))
    else $error("eviction from an empty store");

endmodule

@@ design/fifo_evicting_key_value_cache.sv @@
// Keyed store with oldest-first eviction, one item at a time.
// A search walks the held entries one per cycle from one memory read port. A new word is
// taken the cycle after the item is done, even while its result waits, so items never
// overlap. Reset clears the count, limit 65.
module fifo_evicting_key_value_cache #(
  parameter int unsigned DEPTH = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // eviction limit register write
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,
  // input words
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // key[31:0], value[63:32]
  input  logic [1:0]    s_axis_tuser,   // op[1:0]
  // result words
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // read_value[31:0], evicted_key[63:32],
                                        // evicted_value[95:64], entry_total[103:96]
  output logic [1:0]    m_axis_tuser    // found[0], evicted[1]
);

  fekvc_pkg::cmd_t  cmd;
  fekvc_pkg::stat_t stat;

  // sequencing
  fekvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage and result register
  fekvc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

@@ verif/tb_fifo_evicting_key_value_cache.sv @@
// testbench for the fifo evicting key value cache: directed and random stream traffic
`timescale 1ns / 1ps

module tb_fifo_evicting_key_value_cache;

  localparam int unsigned CacheDepth = 128;
  localparam int unsigned DrainCycles = 2 * CacheDepth + 40;

  // one result word split into its fields
  typedef struct {
    logic        found;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
    logic [31:0] evicted_value;
    logic [7:0]  entry_total;
  } cache_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [6:0]    cfg_wdata_i;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [63:0]   s_axis_tdata;   // key[31:0], value[63:32]
  logic [1:0]    s_axis_tuser;   // op[1:0]
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [103:0]  m_axis_tdata;   // read_value, evicted_key, evicted_value, entry_total
  logic [1:0]    m_axis_tuser;   // found[0], evicted[1]

  // mirror of the cache contents, oldest entry first
  logic [31:0]   held_keys[$];
  logic [31:0]   held_vals[$];
  logic [6:0]    cap_limit = fekvc_pkg::LimitReset;

  cache_result_t pending_results[$];
  cache_result_t want;
  cache_result_t got;
  int unsigned   err_cnt = 0;
  int unsigned   ready_hold = 0;
  bit            calm = 1'b0;

  fifo_evicting_key_value_cache #(
    .DEPTH(CacheDepth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // position of a held key, -1 when absent
  function automatic int find_held(logic [31:0] k);
    for (int i = 0; i < held_keys.size(); i++) begin
      if (held_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // apply one accepted word to the mirror and return the result it must produce
  function automatic cache_result_t apply_cache_op(fekvc_pkg::op_e op, logic [31:0] k,
                                                   logic [31:0] v);
    cache_result_t r;
    int pos;
    r = '{found: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0,
          evicted_value: '0, entry_total: '0};
    pos = find_held(k);
    case (op)
      fekvc_pkg::OP_INSERT: begin
        if (v != '0 && pos < 0) begin
          if (held_keys.size() > cap_limit || held_keys.size() >= CacheDepth) begin
            r.evicted       = 1'b1;
            r.evicted_key   = held_keys.pop_front();
            r.evicted_value = held_vals.pop_front();
          end
          if (held_keys.size() < CacheDepth) begin
            held_keys.push_back(k);
            held_vals.push_back(v);
          end
          r.found = 1'b1;
        end
      end
      fekvc_pkg::OP_LOOKUP: begin
        if (pos >= 0) begin
          r.found      = 1'b1;
          r.read_value = held_vals[pos];
        end
      end
      fekvc_pkg::OP_REMOVE: begin
        if (pos >= 0) begin
          r.found      = 1'b1;
          r.read_value = held_vals[pos];
          held_keys.delete(pos);
          held_vals.delete(pos);
        end
      end
      default: ;
    endcase
    r.entry_total = 8'(held_keys.size());
    return r;
  endfunction

  // send one word, with an occasional idle burst in front of it
  task automatic send_word(fekvc_pkg::op_e op, logic [31:0] k, logic [31:0] v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, k};
    s_axis_tuser  <= op;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    pending_results.push_back(apply_cache_op(op, k, v));
  endtask

  // hold the input side until every outstanding result is back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [6:0] lim);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_limit = lim;
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // result side stalls in random bursts
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold    <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      ready_hold    <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result check, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.read_value    = m_axis_tdata[31:0];
      got.evicted_key   = m_axis_tdata[63:32];
      got.evicted_value = m_axis_tdata[95:64];
      got.entry_total   = m_axis_tdata[103:96];
      got.found         = m_axis_tuser[0];
      got.evicted       = m_axis_tuser[1];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h/%h",
                 $time, m_axis_tuser, m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        compare_field("found", 32'(want.found), 32'(got.found));
        compare_field("read_value", want.read_value, got.read_value);
        compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
        compare_field("evicted_key", want.evicted_key, got.evicted_key);
        compare_field("evicted_value", want.evicted_value, got.evicted_value);
        compare_field("entry_total", 32'(want.entry_total), 32'(got.entry_total));
      end
    end
  end

  // misses on empty store, extreme keys and values, rejected inserts, unused op
  task automatic test_basic_ops();
    send_word(fekvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(fekvc_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(fekvc_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(fekvc_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(fekvc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
    send_word(fekvc_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0005);
    send_word(fekvc_pkg::OP_INSERT, 32'h0000_0007, 32'h0000_0000);
    send_word(fekvc_pkg::OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
    send_word(fekvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(fekvc_pkg::OP_LOOKUP, 32'h0000_0007, 32'h0000_0000);
    send_word(fekvc_pkg::OP_NOP, 32'h0000_0000, 32'h0000_0000);
    send_word(fekvc_pkg::OP_REMOVE, 32'h0000_0000, 32'hDEAD_BEEF);
    send_word(fekvc_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_word(fekvc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // oldest-first eviction at limit zero and two, removal from the middle
  task automatic test_eviction_order();
    write_limit(7'd0);
    send_word(fekvc_pkg::OP_INSERT, 32'h0000_0A01, 32'h1111_0001);
    send_word(fekvc_pkg::OP_INSERT, 32'h0000_0A02, 32'h1111_0002);
    send_word(fekvc_pkg::OP_LOOKUP, 32'h0000_0A01, 32'h0000_0000);
    send_word(fekvc_pkg::OP_LOOKUP, 32'h0000_0A02, 32'h0000_0000);
    write_limit(7'd2);
    send_word(fekvc_pkg::OP_INSERT, 32'h0000_0A03, 32'h1111_0003);
    send_word(fekvc_pkg::OP_INSERT, 32'h0000_0A04, 32'h1111_0004);
    send_word(fekvc_pkg::OP_INSERT, 32'h0000_0A05, 32'h1111_0005);
    send_word(fekvc_pkg::OP_REMOVE, 32'h0000_0A04, 32'h0000_0000);
    send_word(fekvc_pkg::OP_INSERT, 32'h0000_0A06, 32'h1111_0006);
    send_word(fekvc_pkg::OP_INSERT, 32'h0000_0A07, 32'h1111_0007);
    send_word(fekvc_pkg::OP_INSERT, 32'h0000_0A05, 32'h2222_0005);
    send_word(fekvc_pkg::OP_LOOKUP, 32'h0000_0A05, 32'h0000_0000);
  endtask

  // fill all entries at the top limit, evict at full, then empty the store
  task automatic test_full_store();
    logic [31:0] snapshot[$];
    logic [31:0] k;
    write_limit(7'd127);
    for (int i = 0; i < CacheDepth + 2; i++) begin
      send_word(fekvc_pkg::OP_INSERT, 32'hA500_0000 | i, $urandom | 32'h1);
    end
    send_word(fekvc_pkg::OP_LOOKUP, held_keys[held_keys.size() - 1], $urandom);
    send_word(fekvc_pkg::OP_REMOVE, held_keys[CacheDepth / 2], $urandom);
    send_word(fekvc_pkg::OP_INSERT, 32'h5A00_0001, 32'h8000_0000);
    send_word(fekvc_pkg::OP_INSERT, 32'h5A00_0002, 32'h7FFF_FFFF);
    snapshot = held_keys;
    for (int j = 0; snapshot.size() != 0; j++) begin
      if (j % 2 == 0) k = snapshot.pop_front();
      else k = snapshot.pop_back();
      send_word(fekvc_pkg::OP_REMOVE, k, $urandom);
    end
  endtask

  // random traffic over a small key pool so hits, evictions and removals are common
  task automatic random_phase(logic [6:0] lim, int unsigned n_items);
    logic [31:0]    pool[$];
    logic [31:0]    k;
    logic [31:0]    v;
    fekvc_pkg::op_e op;
    int unsigned    pool_n;
    int unsigned    r;
    write_limit(lim);
    pool_n = lim + 2 + $urandom_range(0, 6);
    if (pool_n > 40) pool_n = 40;
    for (int i = 0; i < pool_n; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) pool.push_back(32'h0000_0000);
      else if (r == 1) pool.push_back(32'hFFFF_FFFF);
      else pool.push_back($urandom);
    end
    for (int i = 0; i < n_items; i++) begin
      // let the cache run dry once per phase
      if (i == n_items / 2) wait_idle();
      r = $urandom_range(0, 99);
      k = pool[$urandom_range(0, pool.size() - 1)];
      v = $urandom;
      if ($urandom_range(0, 15) == 0) v = '0;
      if (r < 45) op = fekvc_pkg::OP_INSERT;
      else if (r < 70) op = fekvc_pkg::OP_LOOKUP;
      else if (r < 90) op = fekvc_pkg::OP_REMOVE;
      else if (r < 95) op = fekvc_pkg::OP_NOP;
      else begin
        op = fekvc_pkg::op_e'($urandom_range(0, 3));
        k  = $urandom;
      end
      send_word(op, k, v);
    end
  endtask

  task automatic test_random_traffic();
    random_phase(7'd3, 100);
    random_phase(7'd0, 100);
    random_phase(7'd12, 100);
    random_phase(7'd1, 100);
    random_phase(7'd30, 100);
    random_phase(fekvc_pkg::LimitReset, 100);
    random_phase(7'd127, 100);
    random_phase(7'd5, 100);
  endtask

  // closing stretch with both sides running flat out
  task automatic test_quiet_tail();
    wait_idle();
    calm = 1'b1;
    random_phase(7'd7, 100);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = fekvc_pkg::OP_INSERT;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_eviction_order();
    test_full_store();
    test_random_traffic();
    test_quiet_tail();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #24_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
